// ----- rtl/group_reverse_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// Group reverse buffer assertion macros
// Shared concurrent assertion forms, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef GROUP_REVERSE_BUFFER_MACROS_SVH
`define GROUP_REVERSE_BUFFER_MACROS_SVH

// Condition must never hold outside reset.
`define GRB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent on one edge implies consequent on the same edge.
`define GRB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/grb_pkg.sv -----
// ----------------------------------------------------------------------------
// Group reverse buffer package
// Widths, bank layout and the structs passed between front, queue and back.
// ----------------------------------------------------------------------------
package grb_pkg;

  localparam int MAX_GROUP = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = IDX_W + 1;   // one bank bit on top
  localparam int DEPTH     = 2 * MAX_GROUP;

  // closed group handed from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             seq_last;
  } grb_desc_t;

  // buffer write request from the front
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } grb_wr_t;

  // bank handed back once its last read is issued
  typedef struct packed {
    logic en;
    logic bank;
  } grb_rel_t;

endpackage

// ----- rtl/grb_front.sv -----
// ----------------------------------------------------------------------------
// Group reverse buffer front end
// Accepts values, fills the current bank and closes a group on size or end.
// ----------------------------------------------------------------------------
module grb_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [grb_pkg::CNT_W-1:0]    group_size,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [grb_pkg::DATA_W-1:0]   in_data,
  input  logic                         in_end,
  output grb_pkg::grb_wr_t             wr,
  output logic                         push,
  output grb_pkg::grb_desc_t           push_desc,
  input  logic                         q_full,
  input  grb_pkg::grb_rel_t            rel
);
  import grb_pkg::*;

  logic [CNT_W-1:0] fill, fill_next;
  logic             wr_bank, wr_bank_next;
  logic [1:0]       busy, busy_next;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] n;
  logic             accept;
  logic             close;

  // effective group size: zero acts as one, saturate at MAX_GROUP
  always_comb begin
    if (group_size == '0) begin
      limit = CNT_W'(1);
    end else if (group_size > CNT_W'(MAX_GROUP)) begin
      limit = CNT_W'(MAX_GROUP);
    end else begin
      limit = group_size;
    end
  end

  assign in_ready = !busy[wr_bank] && !q_full;
  assign accept   = in_valid && in_ready;
  assign n        = fill + CNT_W'(1);
  assign close    = in_end || (n >= limit);

  // buffer write at the current fill position
  assign wr.en   = accept;
  assign wr.addr = {wr_bank, fill[IDX_W-1:0]};
  assign wr.data = in_data;

  // group descriptor
  assign push               = accept && close;
  assign push_desc.bank     = wr_bank;
  assign push_desc.count    = n;
  assign push_desc.seq_last = in_end;

  // fill count and bank ownership
  always_comb begin
    fill_next    = fill;
    wr_bank_next = wr_bank;
    for (int b = 0; b < 2; b++) begin
      busy_next[b] = (busy[b] && !(rel.en && (rel.bank == 1'(b))))
                     || (push && (wr_bank == 1'(b)));
    end
    if (accept) begin
      if (close) begin
        fill_next    = '0;
        wr_bank_next = !wr_bank;
      end else begin
        fill_next = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      wr_bank <= 1'b0;
      busy    <= '0;
    end else begin
      fill    <= fill_next;
      wr_bank <= wr_bank_next;
      busy    <= busy_next;
    end
  end

endmodule

// ----- rtl/grb_queue.sv -----
// ----------------------------------------------------------------------------
// Group reverse buffer descriptor queue
// Two-entry queue of closed groups between the front and the back.
// ----------------------------------------------------------------------------
`include "group_reverse_buffer_macros.svh"

module grb_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  grb_pkg::grb_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output grb_pkg::grb_desc_t pop_desc,
  output logic               valid
);
  import grb_pkg::*;

  grb_desc_t  entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_desc = entry[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_desc;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `GRB_ASSERT_NEVER(a_q_no_overflow, push && full, "descriptor pushed into full queue")
  `GRB_ASSERT_NEVER(a_q_no_underflow, pop && !valid, "descriptor popped from empty queue")

endmodule

// ----- rtl/grb_back.sv -----
// ----------------------------------------------------------------------------
// Group reverse buffer back end
// Holds the two-bank buffer and drains each closed group in reverse order.
// ----------------------------------------------------------------------------
`include "group_reverse_buffer_macros.svh"

module grb_back (
  input  logic                         clk,
  input  logic                         rst,
  input  grb_pkg::grb_wr_t             wr,
  input  logic                         desc_valid,
  input  grb_pkg::grb_desc_t           desc,
  output logic                         desc_pop,
  output grb_pkg::grb_rel_t            rel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [grb_pkg::DATA_W-1:0]   out_data,
  output logic                         out_group_last,
  output logic                         out_seq_last
);
  import grb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // drain control
  logic             active;
  logic             cur_bank;
  logic [IDX_W-1:0] idx;
  logic             cur_last;

  // read stage
  logic              rd_valid;
  logic [DATA_W-1:0] rd_data;
  logic              rd_gl;
  logic              rd_sl;

  // two-entry output buffer
  logic [DATA_W-1:0] f_data [2];
  logic              f_gl   [2];
  logic              f_sl   [2];
  logic              f_wptr, f_rptr;
  logic [1:0]        f_count;

  logic       pop_out;
  logic [1:0] occ_after;
  logic       issue;
  logic       last_issue;

  // issue a read only when the output buffer has room for it
  assign pop_out    = out_valid && out_ready;
  assign occ_after  = f_count + 2'(rd_valid) - 2'(pop_out);
  assign issue      = active && (occ_after < 2'd2);
  assign last_issue = issue && (idx == '0);
  assign desc_pop   = desc_valid && (!active || last_issue);

  assign rel.en   = last_issue;
  assign rel.bank = cur_bank;

  // buffer write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // buffer read port, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[{cur_bank, idx}];
      rd_gl   <= (idx == '0);
      rd_sl   <= (idx == '0) && cur_last;
    end
  end

  // drain sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (desc_pop) begin
        active <= 1'b1;
      end else if (last_issue) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur_bank <= desc.bank;
      idx      <= IDX_W'(desc.count - CNT_W'(1));
      cur_last <= desc.seq_last;
    end else if (issue) begin
      idx <= idx - IDX_W'(1);
    end
  end

  // output buffer storage
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      f_data[f_wptr] <= rd_data;
      f_gl[f_wptr]   <= rd_gl;
      f_sl[f_wptr]   <= rd_sl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_wptr  <= 1'b0;
      f_rptr  <= 1'b0;
      f_count <= '0;
    end else begin
      if (rd_valid) begin
        f_wptr <= !f_wptr;
      end
      if (pop_out) begin
        f_rptr <= !f_rptr;
      end
      f_count <= f_count + 2'(rd_valid) - 2'(pop_out);
    end
  end

  assign out_valid      = (f_count != 2'd0);
  assign out_data       = f_data[f_rptr];
  assign out_group_last = f_gl[f_rptr];
  assign out_seq_last   = f_sl[f_rptr];

  `GRB_ASSERT_NEVER(a_out_no_overflow, (f_count == 2'd2) && rd_valid && !pop_out, "output buffer overflow")
  `GRB_ASSERT_IMPLY(a_rel_while_active, rel.en, active, "bank released with no group draining")

endmodule

// ----- rtl/group_reverse_buffer.sv -----
// ----------------------------------------------------------------------------
// Group reverse buffer
// Reverses a value stream in groups of group_size; a sequence end closes
// the last, possibly short, group.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_ready  | value, seq_end
//  output   | out_valid / out_ready| out_value, group_last, seq_last
//  config   | cfg_wen              | cfg_wdata (group_size)
//
//  Input takes one value per cycle while the bank being filled is free; two
//  banks of 64 entries let one group fill while the previous one drains.
//  A group of n values drains at one result per cycle while out_ready is
//  held high, paced by the single buffer read port.
//  Input stalls only when both banks hold groups not yet fully read.
//  Synchronous reset, no clearing pass; group_size resets to 1.
// ----------------------------------------------------------------------------
module group_reverse_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  value,
  input  logic                seq_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_value,
  output logic                group_last,
  output logic                seq_last
);
  import grb_pkg::*;

  logic [CNT_W-1:0]  group_size;
  grb_wr_t           wr;
  logic              push;
  grb_desc_t         push_desc;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  grb_desc_t         q_desc;
  grb_rel_t          rel;
  logic [DATA_W-1:0] out_data;

  // group size register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= CNT_W'(1);
    end else if (cfg_wen) begin
      group_size <= cfg_wdata;
    end
  end

  grb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (value),
    .in_end     (seq_end),
    .wr         (wr),
    .push       (push),
    .push_desc  (push_desc),
    .q_full     (q_full),
    .rel        (rel)
  );

  grb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_desc),
    .valid     (q_valid)
  );

  grb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .desc_valid     (q_valid),
    .desc           (q_desc),
    .desc_pop       (q_pop),
    .rel            (rel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .out_group_last (group_last),
    .out_seq_last   (seq_last)
  );

  assign out_value = $signed(out_data);

endmodule

// ----- tb/group_reverse_buffer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group reverse buffer testbench
// Streams values with sequence-end marks through the block under random
// input gaps and output stalls. A local model buffers each group and queues
// the reversed results; every result leaving the block is checked field by
// field against the oldest queued one. Group size is changed between phases
// while no result is outstanding: zero, one, full depth and above.
// ----------------------------------------------------------------------------
module group_reverse_buffer_test;
  import grb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;       // quiet time before a size change
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_ITEMS  = 128;

  // one queued request: either a value or a group size change
  typedef struct {
    bit                 is_cfg;
    logic [6:0]         size;
    logic signed [31:0] value;
    logic               seq_end;
  } grb_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               group_last;
    logic               seq_last;
  } rev_result_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_wen    = 1'b0;
  logic [6:0]         cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic signed [31:0] value      = '0;
  logic               seq_end    = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [31:0] out_value;
  logic               group_last;
  logic               seq_last;

  grb_req_t    pending[$];
  rev_result_t rev_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // model state
  logic signed [31:0] held [MAX_GROUP];
  int unsigned        fill_cnt = 0;
  logic [6:0]         grp_size = 7'd1;

  group_reverse_buffer uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .seq_end    (seq_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .group_last (group_last),
    .seq_last   (seq_last)
  );

  always #10 clk = ~clk;

  // group size in force: zero acts as one, large values saturate
  function automatic int unsigned active_size();
    if (grp_size == 0) return 1;
    if (grp_size > MAX_GROUP) return MAX_GROUP;
    return grp_size;
  endfunction

  // buffer one value; on a closed group queue its values in reverse order
  task automatic buffer_and_reverse(input logic signed [31:0] v, input logic fin);
    int unsigned lim;
    int unsigned n;
    rev_result_t r;
    lim = active_size();
    if (fill_cnt < MAX_GROUP) begin
      held[fill_cnt] = v;
      fill_cnt++;
    end
    if (fill_cnt >= lim || fin) begin
      n = fill_cnt;
      for (int unsigned k = 0; k < n; k++) begin
        r.value      = held[n - 1 - k];
        r.group_last = (k + 1 == n);
        r.seq_last   = (k + 1 == n) && fin;
        rev_expected.push_back(r);
      end
      fill_cnt = 0;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic signed [31:0] v, input logic fin);
    grb_req_t q;
    q.is_cfg  = 1'b0;
    q.size    = '0;
    q.value   = v;
    q.seq_end = fin;
    pending.push_back(q);
  endtask

  task automatic add_cfg(input logic [6:0] s);
    grb_req_t q;
    q.is_cfg  = 1'b1;
    q.size    = s;
    q.value   = '0;
    q.seq_end = 1'b0;
    pending.push_back(q);
  endtask

  // request driver: presents queued values, applies size changes when quiet
  always @(posedge clk) begin : drive
    grb_req_t    head;
    logic        valid_n;
    logic        wen_n;
    int unsigned in_gap;
    int unsigned quiet;
    bit          in_calm;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_wen  <= 1'b0;
      in_gap   = 0;
      quiet    = 0;
      in_calm  = 1'b0;
    end else begin
      valid_n = in_valid;
      wen_n   = 1'b0;
      if (in_valid && in_ready) begin
        buffer_and_reverse(value, seq_end);
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          if (pending[0].is_cfg) begin
            if (quiet >= SETTLE_CYCLES) begin
              head = pending.pop_front();
              wen_n = 1'b1;
              cfg_wdata <= head.size;
              grp_size = head.size;
              quiet  = 0;
              in_gap = 1;
            end
          end else begin
            head = pending.pop_front();
            valid_n = 1'b1;
            value   <= head.value;
            seq_end <= head.seq_end;
            if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
            in_gap = pick_gap(in_calm);
          end
        end
      end
      // quiet: nothing outstanding and no request on the bus
      if (rev_expected.size() == 0 && !in_valid && !valid_n && !wen_n) quiet++;
      else quiet = 0;
      in_valid <= valid_n;
      cfg_wen  <= wen_n;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : watch
    rev_result_t want;
    int unsigned out_stall;
    bit          out_calm;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
      out_calm  = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rev_expected.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result: expected none, actual value %0d gl %b sl %b",
                   $time, out_value, group_last, seq_last);
        end else begin
          want = rev_expected.pop_front();
          if (out_value !== want.value) begin
            mismatches++;
            $display("%0t ns: out_value expected %0d, actual %0d",
                     $time, want.value, out_value);
          end
          if (group_last !== want.group_last) begin
            mismatches++;
            $display("%0t ns: group_last expected %b, actual %b",
                     $time, want.group_last, group_last);
          end
          if (seq_last !== want.seq_last) begin
            mismatches++;
            $display("%0t ns: seq_last expected %b, actual %b",
                     $time, want.seq_last, seq_last);
          end
        end
      end
      if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned phase;
    int unsigned len;
    int unsigned r;
    logic [6:0]  sz;
    logic        fin;

    // default size one: every value leaves at once
    add_item(32'sh7FFF_FFFF, 1'b0);
    add_item(32'sh8000_0000, 1'b1);
    // full group of three, then a short closing group
    add_cfg(7'd3);
    add_item(32'sd1, 1'b0);
    add_item(32'sd2, 1'b0);
    add_item(32'sd3, 1'b0);
    add_item(-32'sd1, 1'b0);
    add_item(32'sd0, 1'b1);
    // size zero behaves as one
    add_cfg(7'd0);
    add_item(32'sd5, 1'b0);
    add_item(-32'sd5, 1'b1);
    // size lowered with two values buffered: third value flushes all three
    add_cfg(7'd4);
    add_item(32'sd10, 1'b0);
    add_item(32'sd11, 1'b0);
    add_cfg(7'd2);
    add_item(32'sd12, 1'b0);
    add_item(32'sd13, 1'b1);
    // full depth, then above it (saturates); one-value sequence
    add_cfg(7'd64);
    add_item(32'sd20, 1'b0);
    add_item(32'sd21, 1'b1);
    add_cfg(7'd127);
    add_item(32'sd30, 1'b1);

    // random phases; first one uses a saturated size and enough values for a whole group
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      if (phase == 0) begin
        sz = 7'd127;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0)       sz = 7'd0;
        else if (r < 15)  sz = 7'($urandom_range(1, 8));
        else if (r < 19)  sz = 7'($urandom_range(9, 24));
        else              sz = 7'($urandom_range(65, 127));
      end
      add_cfg(sz);
      if (sz > 24) len = MAX_GROUP + $urandom_range(1, 4);
      else len = $urandom_range(8, 24);
      for (int unsigned i = 0; i < len; i++) begin
        if (sz > 24) fin = ($urandom_range(0, 39) == 0);
        else fin = ($urandom_range(0, 7) == 0);
        add_item(rand_value(), fin);
      end
      total += len;
      phase++;
    end
    // close whatever is still buffered
    add_item(rand_value(), 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid || rev_expected.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
